// ----- rtl/core/gapa_pkg.sv -----
// ----------------------------------------------------------------------------
// gapa_pkg
// Shared widths, function codes and control/status bundles for the
// entry table with lazy global assign and point add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gapa_pkg;

   localparam int FUNC_W    = 2;
   localparam int INDEX_W   = 10;
   localparam int OPERAND_W = 32;
   localparam int VALUE_W   = 48;
   localparam int EPOCH_W   = 8;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ASSIGN = 2'd0,
      FUNC_ADD    = 2'd1,
      FUNC_QUERY  = 2'd2
   } func_type;

   typedef struct packed {
      logic capture;
      logic load_base;
      logic epoch_inc;
      logic epoch_restart;
      logic sweep_write;
      logic write_entry;
      logic load_rsp;
   } gapa_cmd_type;

   typedef struct packed {
      logic is_assign;
      logic is_add;
      logic is_query;
      logic epoch_max;
      logic sweep_last;
   } gapa_status_type;

endpackage

`default_nettype wire

// ----- rtl/core/gapa_if.sv -----
// ----------------------------------------------------------------------------
// gapa_if
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gapa_req_if import gapa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [FUNC_W-1:0]    func;
   logic [INDEX_W-1:0]   entry_index;
   logic [OPERAND_W-1:0] operand_value;

   modport source (output valid, output func, output entry_index, output operand_value,
                   input ready);
   modport sink   (input valid, input func, input entry_index, input operand_value,
                   output ready);
endinterface

interface gapa_rsp_if import gapa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] entry_value;

   modport source (output valid, output entry_value, input ready);
   modport sink   (input valid, input entry_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gapa_ram.sv -----
// ----------------------------------------------------------------------------
// gapa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gapa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/gapa_datapath.sv -----
// ----------------------------------------------------------------------------
// gapa_datapath
// Base register, epoch tag, delta table, shared saturating adder and
// response register for the entry table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gapa_datapath import gapa_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire gapa_cmd_type         cmd,
   input  wire logic [FUNC_W-1:0]    req_func,
   input  wire logic [INDEX_W-1:0]   req_entry_index,
   input  wire logic [OPERAND_W-1:0] req_operand_value,
   output gapa_status_type           status,
   output logic      [VALUE_W-1:0]   rsp_entry_value
);

   localparam int AW    = $clog2(DEPTH);
   localparam int RAM_W = EPOCH_W + VALUE_W;
   localparam logic [AW-1:0] SWEEP_LAST = AW'(DEPTH - 1);

   logic [OPERAND_W-1:0] base_ff, base_in;
   logic [EPOCH_W-1:0]   epoch_ff, epoch_in;
   logic [AW-1:0]        sweep_ff, sweep_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [OPERAND_W-1:0] op_ff, op_in;
   logic [VALUE_W-1:0]   value_ff, value_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [RAM_W-1:0]     wr_data;
   logic [RAM_W-1:0]     rd_data;
   logic                 in_range;
   logic                 entry_live;
   logic [VALUE_W-1:0]   delta_sel;
   logic [OPERAND_W-1:0] addend;
   logic [VALUE_W:0]     sum;
   logic [VALUE_W-1:0]   sum_sat;

   gapa_ram #(
      .WIDTH (RAM_W),
      .DEPTH (DEPTH)
   ) u_delta_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (cmd.capture),
      .rd_addr    (AW'(req_entry_index)),
      .rd_data_ff (rd_data)
   );

   // entry is live only if tagged with the current epoch
   always_comb begin
      in_range   = 32'(req_entry_index) < 32'(DEPTH);
      entry_live = rd_data[RAM_W-1 -: EPOCH_W] == epoch_ff;
      delta_sel  = entry_live ? rd_data[VALUE_W-1:0] : '0;
      addend     = cmd.write_entry ? op_ff : base_ff;
      sum        = (VALUE_W+1)'(delta_sel) + (VALUE_W+1)'(addend);
      sum_sat    = sum[VALUE_W] ? VALUE_MAX : sum[VALUE_W-1:0];

      wr_en   = cmd.write_entry | cmd.sweep_write;
      wr_addr = cmd.sweep_write ? sweep_ff : addr_ff;
      wr_data = cmd.sweep_write ? '0 : {epoch_ff, sum_sat};

      base_in  = cmd.load_base ? req_operand_value : base_ff;
      addr_in  = cmd.capture ? AW'(req_entry_index) : addr_ff;
      op_in    = cmd.capture ? req_operand_value : op_ff;
      value_in = cmd.load_rsp ? sum_sat : value_ff;

      epoch_in = epoch_ff;
      if (cmd.epoch_restart) begin
         epoch_in = EPOCH_W'(1);
      end else if (cmd.epoch_inc) begin
         epoch_in = epoch_ff + EPOCH_W'(1);
      end

      sweep_in = sweep_ff;
      if (cmd.sweep_write) begin
         sweep_in = (sweep_ff == SWEEP_LAST) ? '0 : sweep_ff + AW'(1);
      end

      status.is_assign  = req_func == FUNC_ASSIGN;
      status.is_add     = (req_func == FUNC_ADD) && in_range;
      status.is_query   = (req_func == FUNC_QUERY) && in_range;
      status.epoch_max  = epoch_ff == EPOCH_MAX;
      status.sweep_last = sweep_ff == SWEEP_LAST;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         epoch_ff <= EPOCH_W'(1);
         sweep_ff <= '0;
      end else begin
         base_ff  <= base_in;
         epoch_ff <= epoch_in;
         sweep_ff <= sweep_in;
      end
      addr_ff  <= addr_in;
      op_ff    <= op_in;
      value_ff <= value_in;
   end

   assign rsp_entry_value = value_ff;

endmodule

`default_nettype wire

// ----- rtl/core/gapa_ctrl.sv -----
// ----------------------------------------------------------------------------
// gapa_ctrl
// Sequencer for the entry table: tag sweep, item decode, update and
// response handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gapa_ctrl import gapa_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            rsp_ready,
   input  wire gapa_status_type status,
   output logic                 req_ready,
   output logic                 rsp_valid,
   output gapa_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      query_ff, query_in;
   logic      accept;

   always_comb begin
      req_ready    = state_ff == ST_IDLE;
      accept       = req_valid & req_ready;
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      query_in     = query_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_write = 1'b1;
            if (status.sweep_last) begin
               cmd.epoch_restart = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               query_in    = status.is_query;
               priority if (status.is_assign) begin
                  cmd.load_base = 1'b1;
                  if (status.epoch_max) begin
                     state_in = ST_CLEAR;
                  end else begin
                     cmd.epoch_inc = 1'b1;
                  end
               end else if (status.is_add || status.is_query) begin
                  state_in = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EXEC: begin
            if (!query_ff) begin
               cmd.write_entry = 1'b1;
               state_in        = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         query_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         query_ff     <= query_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/core/global_assign_point_add_array.sv -----
// ----------------------------------------------------------------------------
// global_assign_point_add_array
// Entry table with lazy assign-all and saturating point add. Entries are
// a global base plus an epoch-tagged delta held in a RAM.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+---------------------------------------
//   req_ch   | in  | valid/ready       | func, entry_index, operand_value
//   rsp_ch   | out | valid/ready       | entry_value (queries only)
//
// An add or query is accepted with a RAM read, then goes to an update or
// response load through one saturating adder. Assign-all finishes on accept.
// Reset starts a tag sweep over all DEPTH entries; every 255th assign-all
// restarts the epoch with another such sweep. req_ch is held off during
// sweeps. A query waits in the execute state while the response register
// is still full; a pending response does not block accepting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module global_assign_point_add_array import gapa_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  wire logic  clock,
   input  wire logic  reset,
   gapa_req_if.sink   req_ch,
   gapa_rsp_if.source rsp_ch
);

   gapa_cmd_type    cmd;
   gapa_status_type status;

   gapa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .cmd       (cmd)
   );

   gapa_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_func          (req_ch.func),
      .req_entry_index   (req_ch.entry_index),
      .req_operand_value (req_ch.operand_value),
      .status            (status),
      .rsp_entry_value   (rsp_ch.entry_value)
   );

`ifndef SYNTH
   a_sweep_blocks_req : assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_write |-> !req_ch.ready)
      else $error("request taken during tag sweep");

   a_no_write_on_capture : assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> !(cmd.write_entry || cmd.sweep_write))
      else $error("table write collides with item capture");

   a_rsp_follows_load : assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_ch.valid)
      else $error("response load did not raise valid");
`endif

endmodule

`default_nettype wire
